FILE: sv/klp_pkg.sv
// Shared types, constants and fixed-point helpers for the kinematic latency predictor.
// No dependencies; every other source file but klp_if uses this package.
`default_nettype none
package klp_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_ITERS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DT        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_LF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEER = 2'd2;

  localparam int REM_W = 56;  // |angle| in Q32, worst case FRAC_BITS = 8
  localparam int ANG_W = 36;
  localparam int CRD_W = 34;

  localparam logic [63:0]             TWO_PI_Q32_U = 64'd26986075410;
  localparam logic signed [ANG_W-1:0] PI_Q32       = 36'sd13493037705;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q32   = 36'sd26986075410;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q32  = 36'sd6746518852;
  localparam logic signed [CRD_W-1:0] GAIN_Q30     = 34'sd652032874;

  typedef struct packed {
    logic [REM_W-1:0]        rem;
    logic                    sgn;
    logic                    flip;
    logic signed [ANG_W-1:0] z;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
  } ang_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] psi;
    logic signed [31:0] v;
    logic signed [31:0] cte;
    logic signed [31:0] epsi;
    logic signed [31:0] vth;
    logic signed [31:0] rate1;
    logic signed [19:0] delta;
    ang_t [1:0]         ang;   // 0: heading, 1: heading error
  } item_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [ANG_W-1:0] r;
    case (i)
      5'd0:  r = 36'sd843314857;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043837;
      5'd3:  r = 36'sd133525159;
      5'd4:  r = 36'sd67021687;
      5'd5:  r = 36'sd33543516;
      5'd6:  r = 36'sd16775851;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194283;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048576;
      5'd11: r = 36'sd524288;
      5'd12: r = 36'sd262144;
      5'd13: r = 36'sd131072;
      5'd14: r = 36'sd65536;
      5'd15: r = 36'sd32768;
      5'd16: r = 36'sd16384;
      5'd17: r = 36'sd8192;
      5'd18: r = 36'sd4096;
      5'd19: r = 36'sd2048;
      5'd20: r = 36'sd1024;
      5'd21: r = 36'sd512;
      5'd22: r = 36'sd256;
      5'd23: r = 36'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [79:0] t);
    logic signed [31:0] r;
    if (t > 80'sd2147483647) r = 32'sh7fffffff;
    else if (t < -80'sd2147483648) r = 32'sh80000000;
    else r = t[31:0];
    return r;
  endfunction

  // round half up by s bits, then saturate; s is always a constant at the call
  function automatic logic signed [31:0] rnd_sat(input logic signed [79:0] p,
                                                 input int unsigned s);
    logic signed [79:0] t;
    t = (p + (80'sd1 <<< (s - 1))) >>> s;
    return sat32(t);
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [79:0] t;
    t = 80'(a) + 80'(b);
    return sat32(t);
  endfunction

endpackage
`default_nettype wire

FILE: sv/klp_if.sv
// Input and output channel interfaces: valid/ready handshake plus payload.
// Stand-alone, no package needed.
`default_nettype none
interface klp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] speed;
  logic signed [31:0] cross_track_err;
  logic signed [31:0] heading_err;
  logic signed [15:0] steer_cmd;
  logic signed [15:0] throttle_cmd;
  modport source (output valid, pos_x, pos_y, heading, speed, cross_track_err,
                  heading_err, steer_cmd, throttle_cmd, input ready);
  modport sink (input valid, pos_x, pos_y, heading, speed, cross_track_err,
                heading_err, steer_cmd, throttle_cmd, output ready);
endinterface

interface klp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pred_x;
  logic signed [31:0] pred_y;
  logic signed [31:0] pred_heading;
  logic signed [31:0] pred_speed;
  logic signed [31:0] pred_cte;
  logic signed [31:0] pred_heading_err;
  modport source (output valid, pred_x, pred_y, pred_heading, pred_speed, pred_cte,
                  pred_heading_err, input ready);
  modport sink (input valid, pred_x, pred_y, pred_heading, pred_speed, pred_cte,
                pred_heading_err, output ready);
endinterface
`default_nettype wire

FILE: sv/kinematic_latency_predict_unit.sv
// Top level of the kinematic latency predictor: config registers and pipeline chain.
// Depends on klp_pkg, klp_if, klp_front, klp_mod_step, klp_fold, klp_cordic_step, klp_tail.
`default_nettype none
// Advances one vehicle state by one latency interval (kinematic bicycle model) in a
// fully pipelined datapath: one transaction is accepted per cycle unless the output
// stalls. The depth is set by the CORDIC (one iteration per stage); the
// modulo-2*pi reduction takes three stages (reciprocal multiply, subtract, one
// correction). Output stalls back up stage by stage, and empty stages keep taking
// new items. Config registers should only be written while no transaction is in flight.
module kinematic_latency_predict_unit
  import klp_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  klp_in_if.sink                     in_ch,
  klp_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int QB = 1;
  localparam int NI = (CORDIC_ITERS < ATAN_LEN) ? CORDIC_ITERS : ATAN_LEN;
  localparam int NL = QB + NI + 2;

  localparam logic [16:0] RST_DT    = 17'((64'd6554 << 8) >> (24 - FRAC_BITS));
  localparam logic [23:0] RST_INVLF = 24'((64'd24545 << 8) >> (24 - FRAC_BITS));
  localparam logic [16:0] RST_STEER = 17'((64'd28596 << 8) >> (24 - FRAC_BITS));

  logic [16:0] dt_seconds;
  logic [23:0] inv_lf;
  logic [16:0] max_steer_rad;

  logic  pv [NL];
  logic  pr [NL];
  item_t pd [NL];

  always_ff @(posedge clk) begin
    if (rst) begin
      dt_seconds    <= RST_DT;
      inv_lf        <= RST_INVLF;
      max_steer_rad <= RST_STEER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DT:        dt_seconds    <= cfg_data[16:0];
        CFG_INV_LF:    inv_lf        <= cfg_data[23:0];
        CFG_MAX_STEER: max_steer_rad <= cfg_data[16:0];
        default:       ;
      endcase
    end
  end

  klp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .dt_seconds(dt_seconds), .inv_lf(inv_lf), .max_steer_rad(max_steer_rad),
    .out_valid(pv[0]), .out_ready(pr[0]), .out_item(pd[0])
  );

  klp_mod_step #(.FRAC_BITS(FRAC_BITS)) u_mod (
    .clk(clk), .rst(rst),
    .in_valid(pv[0]), .in_ready(pr[0]), .in_item(pd[0]),
    .out_valid(pv[QB]), .out_ready(pr[QB]), .out_item(pd[QB])
  );

  klp_fold u_fold (
    .clk(clk), .rst(rst),
    .in_valid(pv[QB]), .in_ready(pr[QB]), .in_item(pd[QB]),
    .out_valid(pv[QB+1]), .out_ready(pr[QB+1]), .out_item(pd[QB+1])
  );

  for (genvar j = 0; j < NI; j++) begin : g_cordic
    klp_cordic_step #(.ITER(j)) u_step (
      .clk(clk), .rst(rst),
      .in_valid(pv[QB+1+j]), .in_ready(pr[QB+1+j]), .in_item(pd[QB+1+j]),
      .out_valid(pv[QB+2+j]), .out_ready(pr[QB+2+j]), .out_item(pd[QB+2+j])
    );
  end

  klp_tail #(.FRAC_BITS(FRAC_BITS)) u_tail (
    .clk(clk), .rst(rst),
    .in_valid(pv[NL-1]), .in_ready(pr[NL-1]), .in_item(pd[NL-1]),
    .dt_seconds(dt_seconds), .out_ch(out_ch)
  );

`ifndef SYNTH
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid right after reset");
  a_cfg_dt: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == CFG_DT) |=> dt_seconds == $past(cfg_data[16:0]))
    else $error("dt register write lost");
  a_backpressure: assert property (@(posedge clk)
    !in_ch.ready |-> (pv[0] && out_ch.valid && !out_ch.ready))
    else $error("input stalled while the output is not stalled");
`endif

endmodule
`default_nettype wire

FILE: sv/klp_front.sv
// Entry stage: steer angle, speed/Lf and throttle products, angle magnitudes in Q32.
// Depends on klp_pkg and klp_if.
`default_nettype none
module klp_front
  import klp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  klp_in_if.sink           in_ch,
  input  wire logic [16:0] dt_seconds,
  input  wire logic [23:0] inv_lf,
  input  wire logic [16:0] max_steer_rad,
  output logic             out_valid,
  input  wire logic        out_ready,
  output item_t            out_item
);

  item_t              nxt;
  logic signed [33:0] st_prod;
  logic signed [33:0] st_rnd;
  logic [31:0]        mag_psi;
  logic [31:0]        mag_epsi;

  assign in_ch.ready = !out_valid || out_ready;

  always_comb begin
    st_prod  = in_ch.steer_cmd * $signed({1'b0, max_steer_rad});
    st_rnd   = (st_prod + 34'sd16384) >>> 15;
    mag_psi  = in_ch.heading[31] ? (~in_ch.heading + 32'd1) : in_ch.heading;
    mag_epsi = in_ch.heading_err[31] ? (~in_ch.heading_err + 32'd1) : in_ch.heading_err;
    nxt       = '0;
    nxt.px    = in_ch.pos_x;
    nxt.py    = in_ch.pos_y;
    nxt.psi   = in_ch.heading;
    nxt.v     = in_ch.speed;
    nxt.cte   = in_ch.cross_track_err;
    nxt.epsi  = in_ch.heading_err;
    nxt.delta = 20'(-st_rnd);
    nxt.rate1 = rnd_sat(in_ch.speed * $signed({1'b0, inv_lf}), FRAC_BITS);
    nxt.vth   = rnd_sat(in_ch.throttle_cmd * $signed({1'b0, dt_seconds}), 15);
    nxt.ang[0].rem = REM_W'(mag_psi) << (32 - FRAC_BITS);
    nxt.ang[0].sgn = in_ch.heading[31];
    nxt.ang[1].rem = REM_W'(mag_epsi) << (32 - FRAC_BITS);
    nxt.ang[1].sgn = in_ch.heading_err[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      out_item <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/klp_mod_step.sv
// Modulo-2*pi reduction of both angle magnitudes in three stages: reciprocal
// multiply for the quotient, subtract of quotient*2*pi, one final correction. Depends on klp_pkg.
`default_nettype none
module klp_mod_step
  import klp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  item_t     in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output item_t     out_item
);

  localparam int           QW      = 24;
  localparam int           QSH     = 34 + FRAC_BITS;
  // floor(2^66 / 2*pi in Q32); the quotient estimate is low by at most one
  localparam logic [127:0] RECIP_W = (128'd1 << 66) / 128'(TWO_PI_Q32_U);
  localparam logic [31:0]  RECIP   = RECIP_W[31:0];

  typedef struct packed {
    item_t              it;
    logic [1:0][QW-1:0] q;
  } red_t;

  red_t        s1;
  red_t        n1;
  item_t       s2;
  item_t       n2;
  item_t       n3;
  logic        v1;
  logic        v2;
  logic        r2;
  logic        r3;
  logic [31:0] mag [2];
  logic [63:0] prod [2];

  assign r3       = !out_valid || out_ready;
  assign r2       = !v2 || r3;
  assign in_ready = !v1 || r2;

  always_comb begin
    n1.it = in_item;
    for (int k = 0; k < 2; k++) begin
      mag[k]  = 32'(in_item.ang[k].rem >> (32 - FRAC_BITS));
      prod[k] = mag[k] * RECIP;
      n1.q[k] = QW'(prod[k] >> QSH);
    end
  end

  always_comb begin
    n2 = s1.it;
    for (int k = 0; k < 2; k++) begin
      n2.ang[k].rem = REM_W'(64'(s1.it.ang[k].rem) - 64'(s1.q[k]) * TWO_PI_Q32_U);
    end
  end

  always_comb begin
    n3 = s2;
    for (int k = 0; k < 2; k++) begin
      if (64'(s2.ang[k].rem) >= TWO_PI_Q32_U) begin
        n3.ang[k].rem = REM_W'(64'(s2.ang[k].rem) - TWO_PI_Q32_U);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1 <= n1;
    if (r2 && v1) s2 <= n2;
    if (r3 && v2) out_item <= n3;
  end

endmodule
`default_nettype wire

FILE: sv/klp_fold.sv
// Signed remainder, wrap into [-pi, pi], fold to +-pi/2 and seed the CORDIC.
// Depends on klp_pkg.
`default_nettype none
module klp_fold
  import klp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  item_t     in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output item_t     out_item
);

  item_t                   nxt;
  logic signed [ANG_W-1:0] r0 [2];
  logic signed [ANG_W-1:0] r1 [2];
  logic signed [ANG_W-1:0] r2 [2];
  logic                    fl [2];

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    nxt = in_item;
    for (int k = 0; k < 2; k++) begin
      r0[k] = $signed({1'b0, in_item.ang[k].rem[ANG_W-2:0]});
      if (in_item.ang[k].sgn) r0[k] = -r0[k];
      if (r0[k] > PI_Q32) r1[k] = r0[k] - TWO_PI_Q32;
      else if (r0[k] < -PI_Q32) r1[k] = r0[k] + TWO_PI_Q32;
      else r1[k] = r0[k];
      fl[k] = 1'b1;
      if (r1[k] > HALF_PI_Q32) r2[k] = r1[k] - PI_Q32;
      else if (r1[k] < -HALF_PI_Q32) r2[k] = r1[k] + PI_Q32;
      else begin
        r2[k] = r1[k];
        fl[k] = 1'b0;
      end
      nxt.ang[k].flip = fl[k];
      nxt.ang[k].z    = (r2[k] + 36'sd2) >>> 2;  // Q32 -> Q30, round half up
      nxt.ang[k].x    = GAIN_Q30;
      nxt.ang[k].y    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/klp_cordic_step.sv
// One rotation-mode CORDIC iteration, applied to both angles side by side.
// Depends on klp_pkg.
`default_nettype none
module klp_cordic_step
  import klp_pkg::*;
#(
  parameter int ITER = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  item_t     in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output item_t     out_item
);

  localparam logic signed [ANG_W-1:0] ATAN = atan_q30(5'(ITER));

  item_t nxt;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    nxt = in_item;
    for (int k = 0; k < 2; k++) begin
      if (!in_item.ang[k].z[ANG_W-1]) begin
        nxt.ang[k].x = in_item.ang[k].x - (in_item.ang[k].y >>> ITER);
        nxt.ang[k].y = in_item.ang[k].y + (in_item.ang[k].x >>> ITER);
        nxt.ang[k].z = in_item.ang[k].z - ATAN;
      end else begin
        nxt.ang[k].x = in_item.ang[k].x + (in_item.ang[k].y >>> ITER);
        nxt.ang[k].y = in_item.ang[k].y - (in_item.ang[k].x >>> ITER);
        nxt.ang[k].z = in_item.ang[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/klp_tail.sv
// Three stages: speed*trig and rate products, scaling by dt, saturated sums.
// Depends on klp_pkg and klp_if; its last stage is the output register.
`default_nettype none
module klp_tail
  import klp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  input  wire logic [16:0] dt_seconds,
  klp_out_if.source        out_ch
);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] psi;
    logic signed [31:0] v;
    logic signed [31:0] cte;
    logic signed [31:0] epsi;
    logic signed [31:0] vth;
    logic signed [31:0] mc;
    logic signed [31:0] ms;
    logic signed [31:0] me;
    logic signed [31:0] mr;
  } tail_t;

  tail_t                   t1;
  tail_t                   t2;
  tail_t                   n1;
  tail_t                   n2;
  logic                    v1;
  logic                    v2;
  logic                    r2;
  logic                    r3;
  logic signed [CRD_W-1:0] cp;
  logic signed [CRD_W-1:0] sp;
  logic signed [CRD_W-1:0] se;
  logic signed [17:0]      dts;

  assign dts      = $signed({1'b0, dt_seconds});
  assign r3       = !out_ch.valid || out_ch.ready;
  assign r2       = !v2 || r3;
  assign in_ready = !v1 || r2;

  always_comb begin
    cp = in_item.ang[0].flip ? -in_item.ang[0].x : in_item.ang[0].x;
    sp = in_item.ang[0].flip ? -in_item.ang[0].y : in_item.ang[0].y;
    se = in_item.ang[1].flip ? -in_item.ang[1].y : in_item.ang[1].y;
    n1.px   = in_item.px;
    n1.py   = in_item.py;
    n1.psi  = in_item.psi;
    n1.v    = in_item.v;
    n1.cte  = in_item.cte;
    n1.epsi = in_item.epsi;
    n1.vth  = in_item.vth;
    n1.mc   = rnd_sat(in_item.v * cp, 30);
    n1.ms   = rnd_sat(in_item.v * sp, 30);
    n1.me   = rnd_sat(in_item.v * se, 30);
    n1.mr   = rnd_sat(in_item.rate1 * in_item.delta, FRAC_BITS);
  end

  always_comb begin
    n2    = t1;
    n2.mc = rnd_sat(t1.mc * dts, FRAC_BITS);
    n2.ms = rnd_sat(t1.ms * dts, FRAC_BITS);
    n2.me = rnd_sat(t1.me * dts, FRAC_BITS);
    n2.mr = rnd_sat(t1.mr * dts, FRAC_BITS);  // heading change
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) out_ch.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) t1 <= n1;
    if (r2 && v1) t2 <= n2;
    if (r3 && v2) begin
      out_ch.pred_x           <= sat_add(t2.px, t2.mc);
      out_ch.pred_y           <= sat_add(t2.py, t2.ms);
      out_ch.pred_heading     <= sat_add(t2.psi, t2.mr);
      out_ch.pred_speed       <= sat_add(t2.v, t2.vth);
      out_ch.pred_cte         <= sat_add(t2.cte, t2.me);
      out_ch.pred_heading_err <= sat_add(t2.epsi, t2.mr);
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/klp_checker.sv
`timescale 1ns / 1ps
// Checker for the kinematic latency predictor: watches both channels and the config
// port, predicts each result from its own copy of the registers and compares. Needs klp_if and klp_pkg.
module klp_checker (
  input  logic                  clk,
  input  logic                  rst,
  klp_in_if                     in_mon,
  klp_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [23:0]           cfg_data,
  output int                    fail_count,
  output int                    pending
);
  typedef struct {
    logic signed [31:0] f [6];
  } motion_t;

  localparam longint PI_Q32      = 64'sd13493037705;
  localparam longint TWO_PI_Q32  = 64'sd26986075410;
  localparam longint HALF_PI_Q32 = 64'sd6746518852;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam int     ITERS       = 16;
  localparam int     FRAC        = 16;

  localparam longint ATAN [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  localparam string FNAME [6] = '{"pred_x", "pred_y", "pred_heading", "pred_speed",
                                  "pred_cte", "pred_heading_err"};

  logic [16:0] dt_reg;
  logic [23:0] inv_lf_reg;
  logic [16:0] steer_reg;
  motion_t     pred_q [$];

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mul_q(input longint a, input longint b, input int s);
    return sat(round_shift(a * b, s));
  endfunction

  function automatic void rot_sincos(input longint ang, output longint c, output longint s);
    longint r, x, y, z, nx;
    bit     flip;
    r = (ang * (64'sd1 <<< (32 - FRAC))) % TWO_PI_Q32;
    flip = 0;
    if (r > PI_Q32) r -= TWO_PI_Q32;
    else if (r < -PI_Q32) r += TWO_PI_Q32;
    if (r > HALF_PI_Q32) begin
      r -= PI_Q32;
      flip = 1;
    end else if (r < -HALF_PI_Q32) begin
      r += PI_Q32;
      flip = 1;
    end
    z = round_shift(r, 2);
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic motion_t predict_motion();
    motion_t m;
    longint px, py, psi, v, cte, epsi, st, th, dt, delta, cp, sp, ce, se, rate, dpsi;
    px = in_mon.pos_x;  py = in_mon.pos_y;  psi = in_mon.heading;
    v = in_mon.speed;   cte = in_mon.cross_track_err;  epsi = in_mon.heading_err;
    st = in_mon.steer_cmd;  th = in_mon.throttle_cmd;
    dt = dt_reg;
    delta = -round_shift(st * longint'(steer_reg), 15);
    rot_sincos(psi, cp, sp);
    rot_sincos(epsi, ce, se);
    rate = mul_q(mul_q(v, longint'(inv_lf_reg), FRAC), delta, FRAC);
    dpsi = mul_q(rate, dt, FRAC);
    m.f[0] = 32'(sat(px + mul_q(mul_q(v, cp, 30), dt, FRAC)));
    m.f[1] = 32'(sat(py + mul_q(mul_q(v, sp, 30), dt, FRAC)));
    m.f[2] = 32'(sat(psi + dpsi));
    m.f[3] = 32'(sat(v + mul_q(th, dt, 15)));
    m.f[4] = 32'(sat(cte + mul_q(mul_q(v, se, 30), dt, FRAC)));
    m.f[5] = 32'(sat(epsi + dpsi));
    return m;
  endfunction

  assign pending = pred_q.size();

  always @(posedge clk) begin
    motion_t exp_m;
    logic signed [31:0] got [6];
    int errs;
    errs = 0;
    if (rst) begin
      dt_reg     <= 17'd6554;
      inv_lf_reg <= 24'd24545;
      steer_reg  <= 17'd28596;
      fail_count <= 0;
      pred_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          klp_pkg::CFG_DT:        dt_reg     <= cfg_data[16:0];
          klp_pkg::CFG_INV_LF:    inv_lf_reg <= cfg_data;
          klp_pkg::CFG_MAX_STEER: steer_reg  <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) pred_q.push_back(predict_motion());
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.pred_x, out_mon.pred_y, out_mon.pred_heading, out_mon.pred_speed,
                out_mon.pred_cte, out_mon.pred_heading_err};
        if (pred_q.size() == 0) begin
          $display("%0t: result with nothing expected, x=%h", $realtime, got[0]);
          errs = errs + 1;
        end else begin
          exp_m = pred_q.pop_front();
          for (int k = 0; k < 6; k++)
            if (got[k] !== exp_m.f[k]) begin
              $display("%0t: %s expected %h actual %h", $realtime, FNAME[k],
                       exp_m.f[k], got[k]);
              errs = errs + 1;
            end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

FILE: tb/sv/tb_kinematic_latency_predict_unit.sv
`timescale 1ns / 1ps
// Top of the predictor testbench: clock, reset, stimulus, config phases and verdict.
// Depends on klp_pkg, klp_if, klp_checker and the block itself.
module tb_kinematic_latency_predict_unit;
  import klp_pkg::*;

  localparam int LIMIT  = 400000;
  localparam int DRAIN  = 60;

  logic clk = 0;
  logic rst = 1;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, pending, cycles = 0, sent = 0, settings = 0;
  bit no_idle = 0;

  klp_in_if  in_ch ();
  klp_out_if out_ch ();

  kinematic_latency_predict_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  klp_checker chk (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending));

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls, same gap shape as the sender
  always @(posedge clk) begin
    int g;
    if (!rst) begin
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1;
    end
  end

  initial begin
    in_ch.valid = 0;
    in_ch.pos_x = 0;  in_ch.pos_y = 0;  in_ch.heading = 0;  in_ch.speed = 0;
    in_ch.cross_track_err = 0;  in_ch.heading_err = 0;
    in_ch.steer_cmd = 0;  in_ch.throttle_cmd = 0;
    out_ch.ready = 0;
  end

  task automatic send_state(input logic [31:0] px, py, psi, v, cte, epsi,
                            input logic [15:0] st, th);
    int g;
    in_ch.valid <= 1;
    in_ch.pos_x <= px;  in_ch.pos_y <= py;  in_ch.heading <= psi;  in_ch.speed <= v;
    in_ch.cross_track_err <= cte;  in_ch.heading_err <= epsi;
    in_ch.steer_cmd <= st;  in_ch.throttle_cmd <= th;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // valid must already be low; wait for the pipe to drain before touching registers
  task automatic write_regs(input logic [23:0] dt, inv_lf, steer);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we <= 1;  cfg_index <= CFG_DT;  cfg_data <= dt;
    @(posedge clk);
    cfg_index <= CFG_INV_LF;  cfg_data <= inv_lf;
    @(posedge clk);
    cfg_index <= CFG_MAX_STEER;  cfg_data <= steer;
    @(posedge clk);
    cfg_we <= 0;
    settings++;
  endtask

  task automatic random_state();
    logic [31:0] f [6];
    if ($urandom_range(0, 3) != 0) begin
      // plausible driving state
      f[0] = $urandom;  f[1] = $urandom;  f[4] = $urandom;
      f[2] = $signed($urandom_range(0, 1310720)) - 655360;
      f[5] = $signed($urandom_range(0, 1310720)) - 655360;
      f[3] = $signed($urandom_range(0, 3932160)) - 1966080;
    end else
      foreach (f[k]) f[k] = $urandom;
    send_state(f[0], f[1], f[2], f[3], f[4], f[5], 16'($urandom), 16'($urandom));
  endtask

  task automatic random_block(input int n);
    for (int i = 0; i < n; i++) random_state();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  localparam logic [31:0] MAXP = 32'h7fffffff;
  localparam logic [31:0] MINN = 32'h80000000;
  localparam logic [31:0] PI_Q16 = 32'd205887;
  localparam logic [31:0] HPI_Q16 = 32'd102944;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: field extremes, angle fold points, full commands, saturation
    send_state(0, 0, 0, 0, 0, 0, 0, 0);
    send_state(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, 16'h7fff, 16'h7fff);
    send_state(MINN, MINN, MINN, MINN, MINN, MINN, 16'h8000, 16'h8000);
    send_state(MAXP, MINN, 0, MAXP, MINN, 0, 16'h8000, 16'h7fff);
    send_state(MINN, MAXP, PI_Q16, MINN, MAXP, -PI_Q16, 16'h7fff, 16'h8000);
    send_state(0, 0, HPI_Q16, 32'h000a0000, 0, -HPI_Q16, 16'h4000, 16'hc000);
    send_state(0, 0, HPI_Q16 + 1, 32'h000a0000, 0, -HPI_Q16 - 1, 16'h8000, 0);
    send_state(0, 0, PI_Q16 + 1, 32'hfff60000, 0, -PI_Q16 - 1, 16'h7fff, 0);
    send_state(0, 0, 32'd411775, 32'h00140000, 0, 32'd411774, 16'h0001, 16'hffff);
    send_state(32'hffffffff, 1, -32'd411775, MAXP, 32'hffffffff, 1, 16'hffff, 1);
    send_state(0, 0, 32'h00100000, 32'h00050000, 0, 32'hfff00000, 16'h2000, 16'h1000);
    send_state(0, 0, 0, MAXP, 0, 0, 16'h8000, 16'h7fff);
    send_state(MAXP, MAXP, 0, MAXP, MAXP, HPI_Q16, 0, 16'h7fff);
    in_ch.valid <= 0;
    @(posedge clk);
    random_block(150);
    // extremes and out-of-range register values
    write_regs(0, 1, 0);
    send_state(MAXP, MAXP, 0, MAXP, MAXP, 0, 16'h8000, 16'h7fff);
    random_block(60);
    write_regs(65536, 24'hffffff, 102944);
    send_state(MAXP, MAXP, 0, MAXP, MAXP, 0, 16'h8000, 16'h8000);
    send_state(0, 0, 0, MINN, 0, 0, 16'h7fff, 16'h7fff);
    no_idle = 1;
    random_block(100);
    no_idle = 0;
    write_regs(24'h01ffff, 0, 24'h01ffff);
    random_block(60);
    write_regs(24'hffffff, 24'h800000, 24'hfe0000);
    random_block(40);
    for (int p = 0; p < 4; p++) begin
      write_regs($urandom_range(0, 65536), $urandom_range(1, 24'hffffff),
                 $urandom_range(0, 102944));
      random_block(70);
    end
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d vehicle states over %0d register settings plus reset defaults,",
             sent, settings);
    $display("with random stalls on both channels and one back-to-back stretch.");
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

FILE: files.f
sv/klp_pkg.sv
sv/klp_if.sv
sv/klp_front.sv
sv/klp_mod_step.sv
sv/klp_fold.sv
sv/klp_cordic_step.sv
sv/klp_tail.sv
sv/kinematic_latency_predict_unit.sv
tb/sv/klp_checker.sv
tb/sv/tb_kinematic_latency_predict_unit.sv
